### rtl/bcf_pkg.sv
// shared types, widths and constants of the bezier curve flattener
`default_nettype none
package bcf_pkg;

  // field and datapath widths
  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 16;
  localparam int COORD_FRC = 8;
  localparam int SEG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 36;
  localparam int RES_W     = 18;
  localparam int STEP_W    = FRAC_W + 1;
  localparam int T_W       = FRAC_W + 2;
  localparam int W_W       = FRAC_W + 2;
  localparam int DIFF_W    = FRAC_W + 1;
  localparam int ACC_W     = 48;
  localparam int DIVR_W    = 15;
  localparam int CNT_W     = 5;

  // iteration counts of the root / divide unit
  localparam int ROOT_STEPS = RES_W;
  localparam int DIV_STEPS  = FRAC_W + COORD_FRC + 1;

  // segment count limits in q.8
  localparam int SEG_MIN_Q = 1 << COORD_FRC;
  localparam int SEG_MAX_Q = 64 << COORD_FRC;

  // parameter space constants
  localparam int T_ONE   = 1 << FRAC_W;
  localparam int T_LIMIT = T_ONE - 1;
  localparam int T_HALF  = 1 << (FRAC_W - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG = 1'd1;
  localparam logic [SEG_W-1:0] MIN_SEG_RST = 7'd4;
  localparam logic [SEG_W-1:0] MAX_SEG_RST = 7'd24;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p0_z;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
  } bcf_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] pt_z;
    logic                      last_point;
  } bcf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_ROOT,
    ST_DIV,
    ST_WGT,
    ST_DOT,
    ST_OUT
  } bcf_state_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_ROOT,
    RD_DIV
  } bcf_rd_mode_t;

  // request to the root / divide unit
  typedef struct packed {
    logic              start_root;
    logic              start_div;
    logic [SUM_W-1:0]  radicand;
    logic [DIVR_W-1:0] divisor;
  } bcf_rd_req_t;

  // response of the root / divide unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] result;
  } bcf_rd_rsp_t;

endpackage
`default_nettype wire

### rtl/bezier_curve_flattener.sv
// top level of the cubic bezier curve flattener
// usage:
//   one input transaction carries a whole cubic curve (four q16.8 control
//   points). in_stall stays high from the transaction until the last point of
//   that curve has been handed to the output register.
//   each output transaction carries one interior curve point; last_point marks
//   the final one. a curve may give no point at all when the step reaches one.
//   the work runs in this order: the squared polygon lengths, the square
//   root and the reciprocal step (one result bit per cycle), then for each
//   point 6 weight products and 12 coordinate products on the one shared
//   multiplier and an output step.
//   the output register lets the next point be computed while one waits; an
//   out_stall holds the point and stops the sequencer once the next is ready.
//   the user writes min_segments and max_segments through cfg_we, cfg_idx
//   and cfg_wdata only while the block is idle; the block does not enforce it.
//   reset (synchronous, rst_n low) returns to idle, drops out_valid and loads
//   the segment clamps with 4 and 24.
`default_nettype none
module bezier_curve_flattener (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bcf_pkg::bcf_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bcf_pkg::bcf_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bcf_pkg::SEG_W-1:0]         cfg_wdata
);
  import bcf_pkg::*;

  // weight phases
  localparam logic [3:0] WP_UU = 4'd0;
  localparam logic [3:0] WP_TT = 4'd1;
  localparam logic [3:0] WP_W0 = 4'd2;
  localparam logic [3:0] WP_W1 = 4'd3;
  localparam logic [3:0] WP_W2 = 4'd4;
  localparam logic [3:0] WP_W3 = 4'd5;
  localparam logic [3:0] SQ_LAST = 4'd8;
  localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - ACC_W'(1);

  bcf_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] c_r [12];
  logic [DIFF_W-1:0]         d_r [9];
  logic [SEG_W-1:0]          min_r, max_r;
  logic [SUM_W-1:0]          sum_r;
  logic [3:0]                cnt_r;
  logic [1:0]                iw_r, k_r;
  logic [STEP_W-1:0]         step_r;
  logic [T_W-1:0]            t_r;
  logic [W_W-1:0]            w_r [4];
  logic [STEP_W-1:0]         uu_r, tt_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [COORD_W-1:0] pt_r [3];
  logic                      ov_r;
  bcf_out_t                  od_r;

  logic signed [COORD_W-1:0] cin [12];
  logic [DIFF_W-1:0]         din [9];
  logic signed [COORD_W:0]   dd;
  logic [COORD_W:0]          dmag;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [STEP_W-1:0]         prod_rnd;
  logic [STEP_W-1:0]         u_w;
  logic [3:0]                ci;
  logic [SUM_W-1:0]          sum_nxt;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [COORD_W-1:0] pt_sat;
  logic [STEP_W-1:0]         seg_a, seg_c, lo_q, hi_q;
  logic [T_W-1:0]            t_next;
  logic                      last_w;
  logic                      out_free;

  bcf_rd_req_t rd_req;
  bcf_rd_rsp_t rd_rsp;

  bcf_mul u_mul (
    .a        (mul_a),
    .b        (mul_b),
    .prod     (prod),
    .prod_rnd (prod_rnd)
  );

  bcf_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rd_req),
    .rsp   (rd_rsp)
  );

  // control point unpack and clamped difference magnitudes
  always_comb begin
    cin[0]  = in_data.p0_x;  cin[1]  = in_data.p0_y;  cin[2]  = in_data.p0_z;
    cin[3]  = in_data.p1_x;  cin[4]  = in_data.p1_y;  cin[5]  = in_data.p1_z;
    cin[6]  = in_data.p2_x;  cin[7]  = in_data.p2_y;  cin[8]  = in_data.p2_z;
    cin[9]  = in_data.p3_x;  cin[10] = in_data.p3_y;  cin[11] = in_data.p3_z;
    dd   = '0;
    dmag = '0;
    for (int j = 0; j < 9; j++) begin
      dd   = (COORD_W+1)'(cin[j+3]) - (COORD_W+1)'(cin[j]);
      dmag = dd[COORD_W] ? (COORD_W+1)'(-dd) : (COORD_W+1)'(dd);
      din[j] = (dmag > (COORD_W+1)'(T_ONE)) ? DIFF_W'(T_ONE) : dmag[DIFF_W-1:0];
    end
  end

  // multiplier operand selection
  always_comb begin
    u_w   = STEP_W'(T_ONE) - t_r[STEP_W-1:0];
    ci    = 4'(k_r) + 4'(iw_r) * 4'd3;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SUMSQ: begin
        mul_a = $signed(MUL_W'(d_r[cnt_r]));
        mul_b = $signed(MUL_W'(d_r[cnt_r]));
      end
      ST_WGT: begin
        unique case (cnt_r)
          WP_UU: begin
            mul_a = $signed(MUL_W'(u_w));
            mul_b = $signed(MUL_W'(u_w));
          end
          WP_TT: begin
            mul_a = $signed(MUL_W'(t_r));
            mul_b = $signed(MUL_W'(t_r));
          end
          WP_W0: begin
            mul_a = $signed(MUL_W'(uu_r));
            mul_b = $signed(MUL_W'(u_w));
          end
          WP_W1: begin
            mul_a = $signed(MUL_W'(uu_r));
            mul_b = $signed(MUL_W'(t_r));
          end
          WP_W2: begin
            mul_a = $signed(MUL_W'(tt_r));
            mul_b = $signed(MUL_W'(u_w));
          end
          WP_W3: begin
            mul_a = $signed(MUL_W'(tt_r));
            mul_b = $signed(MUL_W'(t_r));
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_DOT: begin
        mul_a = $signed(MUL_W'(w_r[iw_r]));
        mul_b = MUL_W'(c_r[ci]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath helpers
  always_comb begin
    sum_nxt = sum_r + SUM_W'(prod[2*DIFF_W-1:0]);
    acc_sum = ((iw_r == 2'd0) ? ACC_W'(T_HALF) : acc_r) + ACC_W'(prod);
    acc_shr = acc_sum >>> FRAC_W;
    if (acc_shr > C_MAX) begin
      pt_sat = C_MAX[COORD_W-1:0];
    end else if (acc_shr < C_MIN) begin
      pt_sat = C_MIN[COORD_W-1:0];
    end else begin
      pt_sat = acc_shr[COORD_W-1:0];
    end
    // segment count clamps in q.8
    seg_a = rd_rsp.result[RES_W-1:1];
    lo_q  = STEP_W'({min_r, {COORD_FRC{1'b0}}});
    hi_q  = STEP_W'({max_r, {COORD_FRC{1'b0}}});
    if (seg_a < lo_q) begin
      seg_c = lo_q;
    end else if (seg_a > hi_q) begin
      seg_c = hi_q;
    end else begin
      seg_c = seg_a;
    end
    if (seg_c < STEP_W'(SEG_MIN_Q)) begin
      seg_c = STEP_W'(SEG_MIN_Q);
    end
    if (seg_c > STEP_W'(SEG_MAX_Q)) begin
      seg_c = STEP_W'(SEG_MAX_Q);
    end
    t_next   = t_r + T_W'(step_r);
    last_w   = (t_next >= T_W'(T_LIMIT));
    out_free = !ov_r || !out_stall;
  end

  // sequencer next state and unit requests
  always_comb begin
    state_nxt          = state_r;
    rd_req.start_root  = 1'b0;
    rd_req.start_div   = 1'b0;
    rd_req.radicand    = sum_nxt;
    rd_req.divisor     = seg_c[DIVR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SUMSQ;
      end
      ST_SUMSQ: begin
        if (cnt_r == SQ_LAST) begin
          rd_req.start_root = 1'b1;
          state_nxt         = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rd_rsp.done) begin
          rd_req.start_div = 1'b1;
          state_nxt        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rd_rsp.done) begin
          state_nxt = (rd_rsp.result >= RES_W'(T_LIMIT)) ? ST_IDLE : ST_WGT;
        end
      end
      ST_WGT: begin
        if (cnt_r == WP_W3) state_nxt = ST_DOT;
      end
      ST_DOT: begin
        if (iw_r == 2'd3 && k_r == 2'd2) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = last_w ? ST_IDLE : ST_WGT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      min_r   <= MIN_SEG_RST;
      max_r   <= MAX_SEG_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MIN_SEG: min_r <= cfg_wdata;
          CFG_MAX_SEG: max_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          for (int j = 0; j < 12; j++) c_r[j] <= cin[j];
          for (int j = 0; j < 9; j++) d_r[j] <= din[j];
          sum_r <= '0;
          cnt_r <= '0;
        end
      end
      ST_SUMSQ: begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
      ST_ROOT: ;
      ST_DIV: begin
        if (rd_rsp.done) begin
          step_r <= rd_rsp.result[STEP_W-1:0];
          t_r    <= T_W'(rd_rsp.result[STEP_W-1:0]);
          cnt_r  <= '0;
        end
      end
      ST_WGT: begin
        unique case (cnt_r)
          WP_UU: uu_r <= prod_rnd;
          WP_TT: tt_r <= prod_rnd;
          WP_W0: w_r[0] <= W_W'(prod_rnd);
          WP_W1: w_r[1] <= W_W'(prod_rnd) + (W_W'(prod_rnd) << 1);
          WP_W2: w_r[2] <= W_W'(prod_rnd) + (W_W'(prod_rnd) << 1);
          WP_W3: w_r[3] <= W_W'(prod_rnd);
          default: ;
        endcase
        cnt_r <= cnt_r + 1'b1;
        iw_r  <= '0;
        k_r   <= '0;
      end
      ST_DOT: begin
        acc_r <= acc_sum;
        iw_r  <= iw_r + 1'b1;
        if (iw_r == 2'd3) begin
          pt_r[k_r] <= pt_sat;
          k_r       <= k_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          od_r.pt_x       <= pt_r[0];
          od_r.pt_y       <= pt_r[1];
          od_r.pt_z       <= pt_r[2];
          od_r.last_point <= last_w;
          t_r             <= t_next;
          cnt_r           <= '0;
        end
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // root / divide unit only runs while a curve is in work
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rd_rsp.busy)
    else $error("root/divide unit busy while idle");

  // the reciprocal is only started with a clamped segment count
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.start_div |-> (rd_req.divisor >= DIVR_W'(SEG_MIN_Q)) &&
                         (rd_req.divisor <= DIVR_W'(SEG_MAX_Q)))
    else $error("segment count out of range");

  // a point is only computed inside the open parameter interval
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DOT) |-> (t_r < T_W'(T_LIMIT)) && (t_r != '0))
    else $error("curve parameter out of range");

  // the step of a curve with points is at least 1/64
  a_step_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WGT) |-> (step_r >= STEP_W'(T_ONE / 64)))
    else $error("step below minimum");

endmodule
`default_nettype wire

### rtl/bcf_mul.sv
// shared signed multiplier with a rounded q1.16 product output
`default_nettype none
module bcf_mul (
  input  logic signed [bcf_pkg::MUL_W-1:0]  a,
  input  logic signed [bcf_pkg::MUL_W-1:0]  b,
  output logic signed [bcf_pkg::PROD_W-1:0] prod,
  output logic        [bcf_pkg::STEP_W-1:0] prod_rnd
);
  import bcf_pkg::*;

  logic signed [PROD_W-1:0] rnd_full;

  // full product and round-half-up fractional product
  always_comb begin
    prod     = a * b;
    rnd_full = prod + PROD_W'(T_HALF);
    prod_rnd = rnd_full[FRAC_W+STEP_W-1:FRAC_W];
  end

endmodule
`default_nettype wire

### rtl/bcf_rootdiv.sv
// iterative square root and reciprocal unit sharing one subtractor
`default_nettype none
module bcf_rootdiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bcf_pkg::bcf_rd_req_t  req,
  output bcf_pkg::bcf_rd_rsp_t  rsp
);
  import bcf_pkg::*;

  bcf_rd_mode_t      mode_r, mode_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  a_r;
  logic [SUM_W-1:0]  b_r;
  logic [SUM_W-1:0]  bit_r;
  logic [DIVR_W-1:0] dvs_r;

  logic [SUM_W-1:0]  rem_sh;
  logic [SUM_W:0]    minu;
  logic [SUM_W:0]    subtr;
  logic [SUM_W:0]    diff;
  logic              ge;
  logic              last_step;

  // shared trial subtraction
  always_comb begin
    rem_sh = {a_r[SUM_W-2:0], (cnt_r == '0)};
    if (mode_r == RD_ROOT) begin
      minu  = {1'b0, a_r};
      subtr = {1'b0, b_r + bit_r};
    end else begin
      minu  = {1'b0, rem_sh};
      subtr = (SUM_W+1)'(dvs_r);
    end
    diff = minu - subtr;
    ge   = ~diff[SUM_W];
    last_step = (mode_r == RD_ROOT) ? (cnt_r == CNT_W'(ROOT_STEPS - 1))
                                    : (cnt_r == CNT_W'(DIV_STEPS - 1));
  end

  // mode sequencing
  always_comb begin
    mode_nxt = mode_r;
    done_nxt = 1'b0;
    if (req.start_root) begin
      mode_nxt = RD_ROOT;
    end else if (req.start_div) begin
      mode_nxt = RD_DIV;
    end else if (mode_r != RD_IDLE && last_step) begin
      mode_nxt = RD_IDLE;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RD_IDLE;
      done_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      done_r <= done_nxt;
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (req.start_root) begin
      a_r   <= req.radicand;
      b_r   <= '0;
      bit_r <= SUM_W'(1) << (2 * (ROOT_STEPS - 1));
      cnt_r <= '0;
    end else if (req.start_div) begin
      a_r   <= '0;
      b_r   <= '0;
      dvs_r <= req.divisor;
      cnt_r <= '0;
    end else if (mode_r == RD_ROOT) begin
      if (ge) begin
        a_r <= diff[SUM_W-1:0];
        b_r <= (b_r >> 1) + bit_r;
      end else begin
        b_r <= b_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
    end else if (mode_r == RD_DIV) begin
      a_r   <= ge ? diff[SUM_W-1:0] : rem_sh;
      b_r   <= {b_r[SUM_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp.busy   = (mode_r != RD_IDLE);
  assign rsp.done   = done_r;
  assign rsp.result = b_r[RES_W-1:0];

endmodule
`default_nettype wire
